>>> src/pnst_pkg.sv
`timescale 1ns / 1ps
// Package for the name segment tokenizer: codes, constants and the queue entry type.
// No dependencies.
package pnst_pkg;

  localparam int DEF_MAX_SEGMENTS = 8;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [63:0] DJB_SEED  = 64'd5381;
  localparam logic [15:0] VALUE_MAX = 16'hFFFF;
  localparam logic [16:0] VALUE_LETTERS = 17'h1FFFF;

  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_UPPER_LO = 8'h41;
  localparam logic [7:0] CH_UPPER_HI = 8'h5A;
  localparam logic [7:0] CH_LOWER_LO = 8'h61;
  localparam logic [7:0] CH_LOWER_HI = 8'h7A;

  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_MANY  = 2'd1;
  localparam logic [1:0] ST_NO_DIGITS = 2'd2;

  localparam logic MODE_OUT = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  // result slots of one entry, in delivery order
  localparam int SLOT_CLOSE   = 0;
  localparam int SLOT_FINAL   = 1;
  localparam int SLOT_SUMMARY = 2;

  typedef struct packed {
    logic [63:0]        hash;
    logic [2:0]         index;
    logic signed [16:0] value;
  } seg_t;

  typedef struct packed {
    logic [2:0]  has;
    seg_t        close_seg;
    seg_t        final_seg;
    logic [63:0] name_hash;
    logic [3:0]  total;
    logic [1:0]  status;
  } entry_t;

endpackage

>>> src/pnst_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the tokenizer: byte input and result output.
// No dependencies.
interface pnst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source(output valid, char_code, last_char, input ready);
  modport sink(input valid, char_code, last_char, output ready);
endinterface

interface pnst_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [63:0]        hash_key;
  logic [2:0]         segment_index;
  logic signed [16:0] segment_value;
  logic [3:0]         segment_total;
  logic [1:0]         status;
  logic               last_of_run;

  modport source(output valid, result_kind, hash_key, segment_index, segment_value,
                 segment_total, status, last_of_run, input ready);
  modport sink(input valid, result_kind, hash_key, segment_index, segment_value,
               segment_total, status, last_of_run, output ready);
endinterface

>>> src/port_name_segment_tokenizer.sv
`timescale 1ns / 1ps
// Name segment tokenizer top level: front end, entry queue, back end.
// Depends on pnst_pkg, pnst_if, pnst_front, pnst_queue, pnst_back.
// Path: a byte's first result is registered in the queue, then in the output register.
// Throughput: one byte per cycle while the queue is not full; results leave one per
//   cycle while output is ready, one result after another (4-entry queue buffers).
// Reset: synchronous rst clears run state, name hash to seed, queue and output.
module port_name_segment_tokenizer #(
  parameter int MAX_SEGMENTS = pnst_pkg::DEF_MAX_SEGMENTS
) (
  input  logic       clk,
  input  logic       rst,
  pnst_in_if.sink    chars,
  pnst_out_if.source results
);
  import pnst_pkg::*;

  logic   push, pop, full, head_valid;
  entry_t push_data, head;

  pnst_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .q_full   (full),
    .push     (push),
    .push_data(push_data)
  );

  pnst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .head_valid(head_valid),
    .head      (head)
  );

  pnst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .results   (results)
  );

endmodule

>>> src/pnst_front.sv
`timescale 1ns / 1ps
// Tokenizer front end: classifies each byte, tracks runs and hashes, and builds
// one queue entry per byte that yields results. Depends on pnst_pkg, pnst_if.
module pnst_front #(
  parameter int MAX_SEGMENTS = pnst_pkg::DEF_MAX_SEGMENTS
) (
  input  logic             clk,
  input  logic             rst,
  pnst_in_if.sink          chars,
  input  logic             q_full,
  output logic             push,
  output pnst_pkg::entry_t push_data
);
  import pnst_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  logic             mode, mode_next;
  logic             run_digits, run_digits_next;
  logic             seen_digits, seen_digits_next;
  logic [63:0]      run_hash, run_hash_next;
  logic [15:0]      run_value, run_value_next;
  logic [CNT_W-1:0] seg_cnt, seg_cnt_next;
  logic             err, err_next;
  logic [63:0]      name_hash, name_hash_next;

  logic             accept;
  logic             is_digit, is_alpha, extend;
  logic [63:0]      sx, seed;
  logic [19:0]      nv;
  logic [CNT_W-1:0] cnt_mid, cnt_fin;
  logic [1:0]       st;
  entry_t           e;

  assign chars.ready = !q_full;
  assign accept      = chars.valid && chars.ready;

  assign is_digit = chars.char_code inside {[CH_DIGIT_LO:CH_DIGIT_HI]};
  assign is_alpha = chars.char_code inside {[CH_UPPER_LO:CH_UPPER_HI],
                                            [CH_LOWER_LO:CH_LOWER_HI]};
  assign sx = {{56{chars.char_code[7]}}, chars.char_code};
  assign name_hash_next = (name_hash << 5) + name_hash + sx;

  assign extend = (mode == MODE_RUN) &&
                  ((is_digit && run_digits) || (is_alpha && !run_digits));
  assign nv = ({4'b0, run_value} << 3) + ({4'b0, run_value} << 1) +
              {16'b0, chars.char_code[3:0]};

  always_comb begin
    mode_next        = mode;
    run_digits_next  = run_digits;
    seen_digits_next = seen_digits;
    run_hash_next    = run_hash;
    run_value_next   = run_value;
    err_next         = err;
    cnt_mid          = seg_cnt;
    cnt_fin          = seg_cnt;
    seed             = '0;
    st               = ST_OK;
    e                = '0;
    if (!err) begin
      if (extend) begin
        run_hash_next = (run_hash << 5) + run_hash + {56'b0, chars.char_code};
        if (run_digits) begin
          run_value_next = (nv > {4'b0, VALUE_MAX}) ? VALUE_MAX : nv[15:0];
        end
      end else begin
        if (mode == MODE_RUN) begin
          e.has[SLOT_CLOSE]      = 1'b1;
          e.close_seg.hash       = run_hash;
          e.close_seg.index      = 3'(seg_cnt);
          e.close_seg.value      = run_digits ? {1'b0, run_value} : VALUE_LETTERS;
          cnt_mid                = seg_cnt + 1'b1;
          mode_next              = MODE_OUT;
        end
        if (is_digit || is_alpha) begin
          if (is_digit) begin
            seen_digits_next = 1'b1;
          end
          if (cnt_mid >= CNT_W'(MAX_SEGMENTS)) begin
            err_next  = 1'b1;
            mode_next = MODE_OUT;
          end else begin
            seed            = DJB_SEED + 64'(cnt_mid) + 64'd1;
            run_hash_next   = (seed << 5) + seed + {56'b0, chars.char_code};
            run_digits_next = is_digit;
            run_value_next  = is_digit ? {12'b0, chars.char_code[3:0]} : 16'b0;
            mode_next       = MODE_RUN;
          end
        end
      end
    end
    cnt_fin = cnt_mid;
    if (chars.last_char) begin
      if (err_next) begin
        st = ST_TOO_MANY;
      end else if (!seen_digits_next) begin
        st = ST_NO_DIGITS;
      end
      if (st == ST_OK && mode_next == MODE_RUN) begin
        e.has[SLOT_FINAL] = 1'b1;
        e.final_seg.hash  = run_hash_next;
        e.final_seg.index = 3'(cnt_mid);
        e.final_seg.value = run_digits_next ? {1'b0, run_value_next} : VALUE_LETTERS;
        cnt_fin           = cnt_mid + 1'b1;
      end
      e.has[SLOT_SUMMARY] = 1'b1;
      e.name_hash         = name_hash_next;
      e.total             = 4'(cnt_fin);
      e.status            = st;
    end
    seg_cnt_next = cnt_mid;
  end

  assign push      = accept && (|e.has);
  assign push_data = e;

  always_ff @(posedge clk) begin
    if (rst || (accept && chars.last_char)) begin
      mode        <= MODE_OUT;
      run_digits  <= 1'b0;
      seen_digits <= 1'b0;
      run_hash    <= '0;
      run_value   <= '0;
      seg_cnt     <= '0;
      err         <= 1'b0;
      name_hash   <= DJB_SEED;
    end else if (accept) begin
      mode        <= mode_next;
      run_digits  <= run_digits_next;
      seen_digits <= seen_digits_next;
      run_hash    <= run_hash_next;
      run_value   <= run_value_next;
      seg_cnt     <= seg_cnt_next;
      err         <= err_next;
      name_hash   <= name_hash_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    seg_cnt <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count beyond limit");

  a_err_no_run: assert property (@(posedge clk) disable iff (rst)
    err |-> mode == MODE_OUT)
    else $error("run open after segment overflow");

  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && chars.last_char) |-> push && push_data.has[SLOT_SUMMARY])
    else $error("last byte without summary");

endmodule

>>> src/pnst_queue.sv
`timescale 1ns / 1ps
// Short entry queue between tokenizer front and back ends.
// Depends on pnst_pkg.
module pnst_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pnst_pkg::entry_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output pnst_pkg::entry_t head
);
  import pnst_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/pnst_back.sv
`timescale 1ns / 1ps
// Tokenizer back end: walks the results of the head entry in order and drives
// the registered result channel. Depends on pnst_pkg, pnst_if.
module pnst_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  pnst_pkg::entry_t head,
  output logic             pop,
  pnst_out_if.source       results
);
  import pnst_pkg::*;

  logic [2:0]         done;
  logic [2:0]         pending, pick, rest;
  logic               load;
  logic               out_valid;
  logic               kind;
  logic [63:0]        hash;
  logic [2:0]         index;
  logic signed [16:0] value;
  logic [3:0]         total;
  logic [1:0]         status;
  logic               last;

  assign pending = head.has & ~done;
  assign pick    = pending & (~pending + 3'd1);
  assign rest    = pending & ~pick;
  assign load    = head_valid && (!out_valid || results.ready);
  assign pop     = load && (rest == 3'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        done      <= pop ? 3'b0 : (done | pick);
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last <= rest == 3'b0;
      if (pick[SLOT_CLOSE] || pick[SLOT_FINAL]) begin
        kind   <= KIND_SEGMENT;
        hash   <= pick[SLOT_CLOSE] ? head.close_seg.hash : head.final_seg.hash;
        index  <= pick[SLOT_CLOSE] ? head.close_seg.index : head.final_seg.index;
        value  <= pick[SLOT_CLOSE] ? head.close_seg.value : head.final_seg.value;
        total  <= '0;
        status <= ST_OK;
      end else begin
        kind   <= KIND_SUMMARY;
        hash   <= head.name_hash;
        index  <= '0;
        value  <= '0;
        total  <= head.total;
        status <= head.status;
      end
    end
  end

  assign results.valid         = out_valid;
  assign results.result_kind   = kind;
  assign results.hash_key      = hash;
  assign results.segment_index = index;
  assign results.segment_value = value;
  assign results.segment_total = total;
  assign results.status        = status;
  assign results.last_of_run   = last;

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.result_kind == KIND_SUMMARY) |-> results.last_of_run)
    else $error("summary not marked last");

  a_segment_clean: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.result_kind == KIND_SEGMENT) |->
      (results.status == ST_OK && results.segment_total == 4'd0))
    else $error("segment result carries summary fields");

endmodule
